/* sv/ohs_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the open addressing hash set core.
package ohs_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = 11;
  localparam int KEY_W = 64;
  localparam int SLOT_W = KEY_W + 2;
  localparam int LOAD_LIMIT = CAPACITY * 3 / 4;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_HAS    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_OCC   = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_t;

  localparam logic [1:0] KS_8  = 2'd0;
  localparam logic [1:0] KS_16 = 2'd1;
  localparam logic [1:0] KS_32 = 2'd2;
  localparam logic [1:0] KS_64 = 2'd3;

endpackage

/* sv/ohs_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual port RAM with registered read.
module ohs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/open_addressing_hash_set_core.sv */
`timescale 1ns / 1ps
// Open addressing hash set core with linear probing over a slot RAM.
// Add/has/remove: ST_HASH hashes the key on one 32x32 multiplier, then ST_RD reads each
// probed slot (one slot RAM read port), ST_CHK checks it and ST_FIN registers the result;
// an add refused at the load limit goes straight to ST_FIN. Clear writes one slot per cycle.
// Throughput: one command at a time; the next beat is taken once the result is registered.
// Reset: a sweep of ST_CLR over all CAPACITY slots empties every slot; no beat is taken until it ends.
module open_addressing_hash_set_core
  import ohs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,     // key_size_code
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,       // key
  input  logic [1:0]  s_tuser,       // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata        // hit_flag, status, entry_count[10:0], zero pad
);

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_HASH, ST_RD, ST_CHK, ST_FIN
  } state_t;

  state_t            state;
  logic [1:0]        key_size_code;
  cmd_t              cmd;
  logic [KEY_W-1:0]  key;
  logic [KEY_W-1:0]  mask;
  logic [KEY_W-1:0]  v;
  logic [KEY_W-1:0]  prod;
  logic [1:0]        mstep;
  logic              round;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W:0]    probe_cnt;
  logic [IDX_W-1:0]  tomb;
  logic              tomb_ok;
  logic [IDX_W-1:0]  where;
  logic              where_ok;
  logic              found;
  logic              refused;
  logic              clr_reply;
  logic [IDX_W-1:0]  clr_idx;
  logic [CNT_W-1:0]  count;
  logic              hit_out;
  logic              status_out;
  logic [CNT_W-1:0]  count_out;

  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;
  logic [63:0]       mix_c;
  logic [63:0]       mixed;
  logic [KEY_W-1:0]  in_key;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic [SLOT_W-1:0] ram_rdata;
  slot_t             rd_state;
  logic [KEY_W-1:0]  rd_key;
  logic              fin_go;
  logic              do_add;
  logic              do_rem;

  always_comb begin
    case (key_size_code)
      KS_8:    mask = 64'h0000_0000_0000_00ff;
      KS_16:   mask = 64'h0000_0000_0000_ffff;
      KS_32:   mask = 64'h0000_0000_ffff_ffff;
      default: mask = 64'hffff_ffff_ffff_ffff;
    endcase
  end

  assign in_key = s_tdata & mask;

  assign mix_c = round ? MIX_C2 : MIX_C1;
  always_comb begin
    case (mstep)
      2'd0:    begin mul_a = v[31:0];  mul_b = mix_c[31:0];  end
      2'd1:    begin mul_a = v[63:32]; mul_b = mix_c[31:0];  end
      default: begin mul_a = v[31:0];  mul_b = mix_c[63:32]; end
    endcase
  end
  assign mul_p = mul_a * mul_b;
  assign mixed = round ? (prod ^ (prod >> 31)) : (prod ^ (prod >> 27));

  assign rd_state = slot_t'(ram_rdata[SLOT_W-1:KEY_W]);
  assign rd_key   = ram_rdata[KEY_W-1:0];

  assign fin_go = (state == ST_FIN) && (!m_tvalid || m_tready);
  assign do_add = (cmd == CMD_ADD) && !refused && !found && where_ok;
  assign do_rem = (cmd == CMD_REMOVE) && found;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = where;
    ram_wdata = {SLOT_EMPTY, key};
    if (state == ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = {SLOT_EMPTY, {KEY_W{1'b0}}};
    end else if (fin_go && (do_add || do_rem)) begin
      ram_we    = 1'b1;
      ram_wdata = {do_add ? SLOT_OCC : SLOT_TOMB, key};
    end
  end

  ohs_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {3'b000, count_out, status_out, hit_out};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      key_size_code <= KS_64;
      clr_idx       <= '0;
      clr_reply     <= 1'b0;
      count         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_size_code <= cfg_wdata;
      end
      if (fin_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_W'(CAPACITY - 1)) begin
            state <= clr_reply ? ST_FIN : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd       <= cmd_t'(s_tuser);
            key       <= in_key;
            v         <= in_key ^ (in_key >> 30);
            mstep     <= 2'd0;
            round     <= 1'b0;
            found     <= 1'b0;
            tomb_ok   <= 1'b0;
            where_ok  <= 1'b0;
            probe_cnt <= '0;
            refused   <= 1'b0;
            if (cmd_t'(s_tuser) == CMD_CLEAR) begin
              clr_reply <= 1'b1;
              clr_idx   <= '0;
              count     <= '0;
              state     <= ST_CLR;
            end else if (cmd_t'(s_tuser) == CMD_ADD && count >= CNT_W'(LOAD_LIMIT)) begin
              refused <= 1'b1;
              state   <= ST_FIN;
            end else begin
              state <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          mstep <= mstep + 1'b1;
          case (mstep)
            2'd0:    prod <= mul_p;
            2'd3: begin
              if (round) begin
                pos   <= mixed[IDX_W-1:0];
                state <= ST_RD;
              end else begin
                v     <= mixed;
                round <= 1'b1;
              end
            end
            default: prod <= prod + {mul_p[31:0], 32'b0};
          endcase
        end
        ST_RD: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          probe_cnt <= probe_cnt + 1'b1;
          pos       <= (pos == IDX_W'(CAPACITY - 1)) ? '0 : pos + 1'b1;
          if (rd_state == SLOT_EMPTY) begin
            where    <= tomb_ok ? tomb : pos;
            where_ok <= 1'b1;
            state    <= ST_FIN;
          end else if (rd_state == SLOT_OCC && (rd_key & mask) == key) begin
            found    <= 1'b1;
            where    <= pos;
            where_ok <= 1'b1;
            state    <= ST_FIN;
          end else begin
            if (rd_state != SLOT_OCC && !tomb_ok) begin
              tomb    <= pos;
              tomb_ok <= 1'b1;
            end
            if (probe_cnt == (IDX_W + 1)'(CAPACITY - 1)) begin
              where    <= (rd_state != SLOT_OCC && !tomb_ok) ? pos : tomb;
              where_ok <= tomb_ok || rd_state != SLOT_OCC;
              state    <= ST_FIN;
            end else begin
              state <= ST_RD;
            end
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            clr_reply <= 1'b0;
            state     <= ST_IDLE;
            case (cmd)
              CMD_ADD: begin
                hit_out    <= do_add;
                status_out <= refused || (!found && !where_ok);
                count_out  <= do_add ? count + 1'b1 : count;
                if (do_add) begin
                  count <= count + 1'b1;
                end
              end
              CMD_HAS: begin
                hit_out    <= found;
                status_out <= 1'b0;
                count_out  <= count;
              end
              CMD_REMOVE: begin
                hit_out    <= found;
                status_out <= 1'b0;
                count_out  <= (found && count != '0) ? count - 1'b1 : count;
                if (found && count != '0) begin
                  count <= count - 1'b1;
                end
              end
              default: begin
                hit_out    <= 1'b0;
                status_out <= 1'b0;
                count_out  <= '0;
              end
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
